[rtl/png_scanline_unfilter_macros.svh]
`ifndef PNG_SCANLINE_UNFILTER_MACROS_SVH
`define PNG_SCANLINE_UNFILTER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define PSU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PSU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/psu_pkg.sv]
package psu_pkg;

	localparam int MAX_ROW_BYTES   = 8192;
	localparam int MAX_PIXEL_BYTES = 8;

	localparam int ROW_AW  = $clog2(MAX_ROW_BYTES);
	localparam int COL_W   = ROW_AW + 1;
	localparam int HIST_AW = (MAX_PIXEL_BYTES > 1) ? $clog2(MAX_PIXEL_BYTES) : 1;

	localparam int BPP_W      = 4;
	localparam int ROW_W      = 14;
	localparam int CMP_W      = (COL_W > ROW_W) ? COL_W : ROW_W;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 14;

	localparam logic [CFG_IDX_W-1:0] CFG_BPP = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW = 1'b1;

	localparam logic [BPP_W-1:0] BPP_RESET = 4'd4;
	localparam logic [ROW_W-1:0] ROW_RESET = 14'd4;

	localparam logic [7:0] FILT_NONE  = 8'd0;
	localparam logic [7:0] FILT_SUB   = 8'd1;
	localparam logic [7:0] FILT_UP    = 8'd2;
	localparam logic [7:0] FILT_AVG   = 8'd3;
	localparam logic [7:0] FILT_PAETH = 8'd4;

	typedef struct packed {
		logic [7:0]        data;
		logic [ROW_AW-1:0] col;
		logic [7:0]        filt;
		logic              first_row;
		logic              last;
	} item_t;

	typedef struct packed {
		logic [7:0] pixel;
		logic       row_end;
		logic       bad;
	} result_t;

	function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
			input logic [7:0] c);
		logic signed [9:0] p;
		logic signed [9:0] pa;
		logic signed [9:0] pb;
		logic signed [9:0] pc;
		logic [7:0]        pick;
		p  = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({2'b00, c});
		pa = p - $signed({2'b00, a});
		pb = p - $signed({2'b00, b});
		pc = p - $signed({2'b00, c});
		if (pa < 0) pa = -pa;
		if (pb < 0) pb = -pb;
		if (pc < 0) pc = -pc;
		if (pa <= pb && pa <= pc) pick = a;
		else if (pb <= pc) pick = b;
		else pick = c;
		return pick;
	endfunction

endpackage

[rtl/png_scanline_unfilter.sv]
// A data byte accepted enters the compute stage, then the result register that drives the output.
// Throughput: one byte per cycle unless stalled, filter bytes included; those give no output.
// The line store is read at the accept edge and written when the byte leaves the compute stage.
// Reset: clears control state and the left/upper-left history; expects a filter byte next.
// Reset registers: pixel stride = 4, row_bytes = 4; the line store is not cleared.
`include "png_scanline_unfilter_macros.svh"

module png_scanline_unfilter (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,   // [7:0] stream_byte
	input  logic [0:0]                      s_tuser,   // [0] frame_start
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [7:0]                      m_tdata,   // [7:0] pixel_byte
	output logic                            m_tlast,
	output logic [0:0]                      m_tuser,   // [0] bad_filter
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_data
);

	logic                      take;
	logic                      data_take;
	logic                      adv_s1;
	psu_pkg::item_t            item;
	logic [psu_pkg::BPP_W-1:0] bpp_eff;
	logic [7:0]                up_byte;
	psu_pkg::result_t          res;

	logic                      valid_s1;
	psu_pkg::item_t            item_s1;
	logic                      valid_s2;
	psu_pkg::result_t          res_s2;

	assign cfg_ready = 1'b1;
	assign adv_s1    = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready  = !valid_s1 || adv_s1;
	assign take      = s_tvalid && s_tready;

	psu_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.take      (take),
		.in_byte   (s_tdata),
		.in_fs     (s_tuser[0]),
		.data_take (data_take),
		.item      (item),
		.bpp_eff   (bpp_eff)
	);

	psu_line_store u_line (
		.clk     (clk),
		.rd_en   (data_take),
		.rd_addr (item.col),
		.rd_data (up_byte),
		.wr_en   (adv_s1),
		.wr_addr (item_s1.col),
		.wr_data (res.pixel)
	);

	psu_recon u_recon (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv_s1),
		.item    (item_s1),
		.up_byte (up_byte),
		.bpp_eff (bpp_eff),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= data_take || (valid_s1 && !adv_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (data_take) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

	assign m_tvalid   = valid_s2;
	assign m_tdata    = res_s2.pixel;
	assign m_tlast    = res_s2.row_end;
	assign m_tuser[0] = res_s2.bad;

	`PSU_ASSERT_NXT(a_s1_holds, valid_s1 && !adv_s1, valid_s1 && $stable(item_s1), "compute stage lost its byte while stalled")
	`PSU_ASSERT_NXT(a_s1_to_s2, adv_s1, valid_s2 && res_s2 == $past(res), "result register missed a transaction")
	`PSU_ASSERT_IMP(a_bad_is_zero, adv_s1 && res.bad, res.pixel == 8'h00, "unknown filter type gave nonzero byte")

endmodule

[rtl/psu_line_store.sv]
module psu_line_store (
	input  logic                        clk,
	input  logic                        rd_en,
	input  logic [psu_pkg::ROW_AW-1:0]  rd_addr,
	output logic [7:0]                  rd_data,
	input  logic                        wr_en,
	input  logic [psu_pkg::ROW_AW-1:0]  wr_addr,
	input  logic [7:0]                  wr_data
);

	logic [7:0] mem [psu_pkg::MAX_ROW_BYTES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// forward a same-edge write so the read sees the newest byte
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && wr_addr == rd_addr) begin
				rd_data <= wr_data;
			end else begin
				rd_data <= mem[rd_addr];
			end
		end
	end

endmodule

[rtl/psu_front.sv]
`include "png_scanline_unfilter_macros.svh"

module psu_front (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [psu_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [psu_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            take,
	input  logic [7:0]                      in_byte,
	input  logic                            in_fs,
	output logic                            data_take,
	output psu_pkg::item_t                  item,
	output logic [psu_pkg::BPP_W-1:0]       bpp_eff
);

	logic [psu_pkg::BPP_W-1:0] bpp_q;
	logic [psu_pkg::ROW_W-1:0] row_q;
	logic [psu_pkg::COL_W-1:0] column_q;
	logic [7:0]                filt_q;
	logic                      first_row_q;

	logic [psu_pkg::CMP_W-1:0] row_wide;
	logic [psu_pkg::COL_W-1:0] row_eff;
	logic [psu_pkg::COL_W-1:0] col_cur;
	logic [psu_pkg::COL_W-1:0] j_raw;
	logic [psu_pkg::COL_W-1:0] j;
	logic                      is_filter;
	logic                      last;

	always_comb begin
		bpp_eff = bpp_q;
		if (bpp_q == '0) bpp_eff = psu_pkg::BPP_W'(1);
		else if (bpp_q > psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES))
			bpp_eff = psu_pkg::BPP_W'(psu_pkg::MAX_PIXEL_BYTES);

		row_wide = psu_pkg::CMP_W'(row_q);
		if (row_wide == '0) row_wide = psu_pkg::CMP_W'(1);
		else if (row_wide > psu_pkg::CMP_W'(psu_pkg::MAX_ROW_BYTES))
			row_wide = psu_pkg::CMP_W'(psu_pkg::MAX_ROW_BYTES);
		row_eff = psu_pkg::COL_W'(row_wide);

		col_cur   = in_fs ? '0 : column_q;
		is_filter = (col_cur == '0);

		j_raw = column_q - psu_pkg::COL_W'(1);
		j     = (j_raw >= row_eff) ? row_eff - psu_pkg::COL_W'(1) : j_raw;
		last  = (j >= row_eff - psu_pkg::COL_W'(1));
	end

	assign data_take      = take && !is_filter;
	assign item.data      = in_byte;
	assign item.col       = j[psu_pkg::ROW_AW-1:0];
	assign item.filt      = filt_q;
	assign item.first_row = first_row_q;
	assign item.last      = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= psu_pkg::BPP_RESET;
			row_q <= psu_pkg::ROW_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				psu_pkg::CFG_BPP: bpp_q <= cfg_wdata[psu_pkg::BPP_W-1:0];
				psu_pkg::CFG_ROW: row_q <= cfg_wdata[psu_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q    <= '0;
			filt_q      <= '0;
			first_row_q <= 1'b1;
		end else if (take) begin
			if (is_filter) begin
				filt_q      <= in_byte;
				column_q    <= psu_pkg::COL_W'(1);
				first_row_q <= first_row_q | in_fs;
			end else if (last) begin
				column_q    <= '0;
				first_row_q <= 1'b0;
			end else begin
				column_q <= j + psu_pkg::COL_W'(2);
			end
		end
	end

	`PSU_ASSERT_NXT(a_fs_opens_row, take && in_fs, column_q == psu_pkg::COL_W'(1) && first_row_q, "frame start not taken as filter byte")
	`PSU_ASSERT_NXT(a_last_closes_row, data_take && last, column_q == '0 && !first_row_q, "row end did not rewind column")
	`PSU_ASSERT_NXT(a_mid_row_advance, data_take && !last, column_q != '0, "column lost mid row")

endmodule

[rtl/psu_recon.sv]
module psu_recon (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       adv,
	input  psu_pkg::item_t             item,
	input  logic [7:0]                 up_byte,
	input  logic [psu_pkg::BPP_W-1:0]  bpp_eff,
	output psu_pkg::result_t           res
);

	logic [7:0] left_q [psu_pkg::MAX_PIXEL_BYTES];
	logic [7:0] upl_q  [psu_pkg::MAX_PIXEL_BYTES];

	logic [psu_pkg::HIST_AW-1:0] sel;
	logic                        use_left;
	logic [7:0]                  a;
	logic [7:0]                  b;
	logic [7:0]                  c;
	logic [8:0]                  sum_ab;
	logic [7:0]                  r;
	logic                        bad;

	always_comb begin
		sel      = psu_pkg::HIST_AW'(bpp_eff - psu_pkg::BPP_W'(1));
		use_left = ({1'b0, item.col} >= psu_pkg::COL_W'(bpp_eff));
		a        = use_left ? left_q[sel] : 8'h00;
		c        = use_left ? upl_q[sel] : 8'h00;
		b        = item.first_row ? 8'h00 : up_byte;
		sum_ab   = {1'b0, a} + {1'b0, b};
		bad      = 1'b0;
		case (item.filt)
			psu_pkg::FILT_NONE:  r = item.data;
			psu_pkg::FILT_SUB:   r = item.data + a;
			psu_pkg::FILT_UP:    r = item.data + b;
			psu_pkg::FILT_AVG:   r = item.data + sum_ab[8:1];
			psu_pkg::FILT_PAETH: r = item.data + psu_pkg::paeth(a, b, c);
			default: begin
				r   = 8'h00;
				bad = 1'b1;
			end
		endcase
	end

	assign res.pixel   = r;
	assign res.row_end = item.last;
	assign res.bad     = bad;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= '0;
				upl_q[i]  <= '0;
			end
		end else if (adv) begin
			left_q[0] <= r;
			upl_q[0]  <= b;
			for (int i = 1; i < psu_pkg::MAX_PIXEL_BYTES; i++) begin
				left_q[i] <= left_q[i-1];
				upl_q[i]  <= upl_q[i-1];
			end
		end
	end

endmodule
